/* design/fra_pkg.sv */
// Shared types, constants and sizes of the fragment reassembly tracker.
package fra_pkg;

  localparam int MAX_SLOTS      = 4;
  localparam int MAX_PACKETS    = 1024;
  localparam int SLOT_W         = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int TOT_W          = $clog2(MAX_PACKETS + 1);
  localparam int WORD_BITS      = 64;
  localparam int BIT_W          = 6;
  localparam int ROWS_PER_SLOT  = (MAX_PACKETS + WORD_BITS - 1) / WORD_BITS;
  localparam int NUM_ROWS       = MAX_SLOTS * ROWS_PER_SLOT;
  localparam int RSEL_W         = (ROWS_PER_SLOT > 1) ? $clog2(ROWS_PER_SLOT) : 1;
  localparam int ROW_W          = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
  localparam logic [31:0] FREE_ID = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    CFG_MAGIC  = 2'd0,
    CFG_STRIDE = 2'd1,
    CFG_HEADER = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_ACCEPTED  = 3'd0,
    ST_SHORT     = 3'd1,
    ST_BAD_MAGIC = 3'd2,
    ST_BAD_INDEX = 3'd3,
    ST_TRUNCATED = 3'd4,
    ST_DUPLICATE = 3'd5,
    ST_OVERRUN   = 3'd6,
    ST_TOO_MANY  = 3'd7
  } status_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_LOOK,
    BK_CHECK
  } back_state_e;

  typedef struct packed {
    status_e     pre;
    logic [31:0] fid;
    logic [15:0] idx;
    logic [15:0] tot;
    logic [15:0] w;
    logic [15:0] h;
    logic [31:0] pay;
    logic [31:0] fbytes;
  } item_t;

  typedef struct packed {
    status_e     status;
    logic [1:0]  slot;
    logic [31:0] offset;
    logic [15:0] length;
    logic        done;
    logic [31:0] done_fid;
    logic [15:0] done_w;
    logic [15:0] done_h;
    logic [31:0] done_bytes;
  } result_t;

endpackage

/* design/fra_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module fra_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/fra_front.sv */
// Front end: header checks and classification of each incoming item.
module fra_front
  import fra_pkg::*;
(
  input  logic [15:0] packet_length_i,
  input  logic [31:0] magic_word_i,
  input  logic [31:0] frame_number_i,
  input  logic [15:0] packet_index_i,
  input  logic [15:0] packet_total_i,
  input  logic [15:0] frame_width_i,
  input  logic [15:0] frame_height_i,
  input  logic [31:0] payload_bytes_i,
  input  logic [31:0] frame_bytes_i,
  input  logic [31:0] magic_i,
  input  logic [7:0]  header_i,
  output item_t       item_o
);

  logic [32:0] need;

  assign need = {25'd0, header_i} + {1'b0, payload_bytes_i};

  always_comb begin
    item_o.fid    = frame_number_i;
    item_o.idx    = packet_index_i;
    item_o.tot    = packet_total_i;
    item_o.w      = frame_width_i;
    item_o.h      = frame_height_i;
    item_o.pay    = payload_bytes_i;
    item_o.fbytes = frame_bytes_i;
    if (packet_length_i < {8'd0, header_i}) begin
      item_o.pre = ST_SHORT;
    end else if (magic_word_i != magic_i) begin
      item_o.pre = ST_BAD_MAGIC;
    end else if (packet_index_i >= packet_total_i) begin
      item_o.pre = ST_BAD_INDEX;
    end else if ({17'd0, packet_length_i} < need) begin
      item_o.pre = ST_TRUNCATED;
    end else if ({16'd0, packet_total_i} > 32'(MAX_PACKETS)) begin
      item_o.pre = ST_TOO_MANY;
    end else begin
      item_o.pre = ST_ACCEPTED;
    end
  end

endmodule

/* design/fra_queue.sv */
// Two-entry queue of classified items between front and back.
module fra_queue
  import fra_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t push_item_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output item_t head_o
);

  item_t      ent_q [2];
  logic       wptr_q, wptr_d, rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign head_o  = ent_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q ^ push_i;
    rptr_d = rptr_q ^ pop_i;
    cnt_d  = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wptr_q] <= push_item_i;
    end
  end

endmodule

/* design/fra_back.sv */
// Back end: slot lookup and allocation, duplicate and overrun checks, result register.
module fra_back
  import fra_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_valid_i,
  input  item_t       q_item_i,
  output logic        q_pop_o,
  input  logic [15:0] stride_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output result_t     out_o
);

  back_state_e state_q, state_d;
  item_t       it_q;
  logic [SLOT_W-1:0] slot_q;
  logic [31:0] off_q;

  logic [31:0]      sid_q   [MAX_SLOTS];
  logic [15:0]      sw_q    [MAX_SLOTS];
  logic [15:0]      sh_q    [MAX_SLOTS];
  logic [31:0]      ssize_q [MAX_SLOTS];
  logic [TOT_W-1:0] stot_q  [MAX_SLOTS];
  logic [TOT_W-1:0] srecv_q [MAX_SLOTS];
  logic [NUM_ROWS-1:0] rvld_q;

  logic    out_valid_q;
  result_t res_q, res_d;
  logic    out_free, load_res;

  logic              hit, any_free;
  logic [SLOT_W-1:0] hit_s, free_s, best_s, pick_s, sel_s;
  logic              do_alloc, do_accept, do_done;

  logic [ROW_W-1:0]     row;
  logic [WORD_BITS-1:0] rdata, wdata;
  logic [BIT_W-1:0]     bsel;
  logic                 seen;
  logic [32:0]          end_pos;
  logic [TOT_W-1:0]     recv_inc;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_o       = res_q;

  always_comb begin
    hit = 1'b0;
    hit_s = '0;
    any_free = 1'b0;
    free_s = '0;
    best_s = '0;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      if (!hit && it_q.fid != FREE_ID && sid_q[i] == it_q.fid) begin
        hit = 1'b1;
        hit_s = SLOT_W'(i);
      end
      if (!any_free && sid_q[i] == FREE_ID) begin
        any_free = 1'b1;
        free_s = SLOT_W'(i);
      end
    end
    for (int i = 1; i < MAX_SLOTS; i++) begin
      if (sid_q[i] < sid_q[best_s]) begin
        best_s = SLOT_W'(i);
      end
    end
    pick_s = hit ? hit_s : (any_free ? free_s : best_s);
  end

  assign sel_s = (state_q == BK_LOOK) ? pick_s : slot_q;
  assign row   = ROW_W'(32'(sel_s) * ROWS_PER_SLOT + 32'(RSEL_W'(it_q.idx >> BIT_W)));
  assign bsel  = it_q.idx[BIT_W-1:0];
  assign seen  = rvld_q[row] && rdata[bsel];
  assign wdata = (rvld_q[row] ? rdata : '0) | (WORD_BITS'(1) << bsel);
  assign end_pos  = {1'b0, off_q} + {1'b0, it_q.pay};
  assign recv_inc = srecv_q[slot_q] + TOT_W'(1);

  fra_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(NUM_ROWS)
  ) u_seen (
    .clk_i  (clk_i),
    .we_i   (do_accept),
    .waddr_i(row),
    .wdata_i(wdata),
    .raddr_i(row),
    .rdata_o(rdata)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (q_valid_i && q_item_i.pre != ST_ACCEPTED && out_free) begin
          state_d = BK_IDLE;
        end else if (q_valid_i && q_item_i.pre == ST_ACCEPTED) begin
          state_d = BK_LOOK;
        end
      end
      BK_LOOK:  state_d = BK_CHECK;
      BK_CHECK: if (out_free) state_d = BK_IDLE;
      default:  state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop_o   = 1'b0;
    load_res  = 1'b0;
    do_alloc  = 1'b0;
    do_accept = 1'b0;
    do_done   = 1'b0;
    res_d     = '0;
    unique case (state_q)
      BK_IDLE: begin
        if (q_valid_i && q_item_i.pre != ST_ACCEPTED) begin
          if (out_free) begin
            q_pop_o  = 1'b1;
            load_res = 1'b1;
            res_d.status = q_item_i.pre;
          end
        end else if (q_valid_i) begin
          q_pop_o = 1'b1;
        end
      end
      BK_LOOK: begin
        do_alloc = !hit;
      end
      BK_CHECK: begin
        if (out_free) begin
          load_res   = 1'b1;
          res_d.slot = 2'(slot_q);
          if (it_q.idx >= 16'(stot_q[slot_q]) || it_q.idx >= 16'(MAX_PACKETS)) begin
            res_d.status = ST_BAD_INDEX;
          end else if (seen) begin
            res_d.status = ST_DUPLICATE;
          end else if (end_pos > {1'b0, ssize_q[slot_q]}) begin
            res_d.status = ST_OVERRUN;
          end else begin
            do_accept     = 1'b1;
            res_d.status  = ST_ACCEPTED;
            res_d.offset  = off_q;
            res_d.length  = it_q.pay[15:0];
            if (recv_inc == stot_q[slot_q]) begin
              do_done          = 1'b1;
              res_d.done       = 1'b1;
              res_d.done_fid   = sid_q[slot_q];
              res_d.done_w     = sw_q[slot_q];
              res_d.done_h     = sh_q[slot_q];
              res_d.done_bytes = ssize_q[slot_q];
            end
          end
        end
      end
      default: begin
        q_pop_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
      rvld_q      <= '0;
      for (int i = 0; i < MAX_SLOTS; i++) begin
        sid_q[i]   <= FREE_ID;
        srecv_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (load_res) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (do_alloc) begin
        sid_q[pick_s]   <= it_q.fid;
        srecv_q[pick_s] <= '0;
        for (int r = 0; r < ROWS_PER_SLOT; r++) begin
          rvld_q[ROW_W'(32'(pick_s) * ROWS_PER_SLOT + r)] <= 1'b0;
        end
      end
      if (do_accept) begin
        rvld_q[row]     <= 1'b1;
        srecv_q[slot_q] <= recv_inc;
      end
      if (do_done) begin
        sid_q[slot_q] <= FREE_ID;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      it_q <= q_item_i;
    end
    if (state_q == BK_LOOK) begin
      slot_q <= pick_s;
      off_q  <= {16'd0, it_q.idx} * {16'd0, stride_i};
    end
    if (do_alloc) begin
      sw_q[pick_s]    <= it_q.w;
      sh_q[pick_s]    <= it_q.h;
      ssize_q[pick_s] <= it_q.fbytes;
      stot_q[pick_s]  <= TOT_W'(it_q.tot);
    end
    if (load_res) begin
      res_q <= res_d;
    end
  end

endmodule

/* design/fragment_reassembly_tracker_unit.sv */
// Top level of the fragment reassembly tracker.
// Takes one parsed datagram header per transfer and returns one result per
// header: a status, the frame slot, the byte range of the frame buffer to
// write and, when the header completes a frame, that frame's description.
// Header checks run in the input cycle; a two-entry queue feeds the slot
// engine. A rejected header is answered from the engine's idle state; any
// other header goes through slot lookup and allocation, then the seen
// bitmap read and the duplicate and overrun checks. The seen bitmap lives in
// a RAM of one 64-bit row per 64 packets of each slot; per-row valid bits
// clear a slot's bitmap at allocation, so no clearing pass runs after reset.
// Configuration must be written only while the block is idle (unenforced).
module fragment_reassembly_tracker_unit
  import fra_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] packet_length_i,
  input  logic [31:0] magic_word_i,
  input  logic [31:0] frame_number_i,
  input  logic [15:0] packet_index_i,
  input  logic [15:0] packet_total_i,
  input  logic [15:0] frame_width_i,
  input  logic [15:0] frame_height_i,
  input  logic [31:0] payload_bytes_i,
  input  logic [31:0] frame_bytes_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [1:0]  slot_number_o,
  output logic [31:0] write_offset_o,
  output logic [15:0] write_length_o,
  output logic        frame_done_o,
  output logic [31:0] done_frame_number_o,
  output logic [15:0] done_width_o,
  output logic [15:0] done_height_o,
  output logic [31:0] done_frame_bytes_o
);

  logic [31:0] magic_q;
  logic [15:0] stride_q;
  logic [7:0]  header_q;
  item_t       front_item, head;
  logic        q_full, q_valid, q_pop, push;
  result_t     res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q  <= '0;
      stride_q <= 16'd1400;
      header_q <= 8'd28;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_MAGIC:  magic_q  <= cfg_data_i;
        CFG_STRIDE: stride_q <= cfg_data_i[15:0];
        CFG_HEADER: header_q <= cfg_data_i[7:0];
        default:    magic_q  <= magic_q;
      endcase
    end
  end

  fra_front u_front (
    .packet_length_i(packet_length_i),
    .magic_word_i   (magic_word_i),
    .frame_number_i (frame_number_i),
    .packet_index_i (packet_index_i),
    .packet_total_i (packet_total_i),
    .frame_width_i  (frame_width_i),
    .frame_height_i (frame_height_i),
    .payload_bytes_i(payload_bytes_i),
    .frame_bytes_i  (frame_bytes_i),
    .magic_i        (magic_q),
    .header_i       (header_q),
    .item_o         (front_item)
  );

  assign in_stall_o = q_full;
  assign push       = in_valid_i && !q_full;

  fra_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_item_i(front_item),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .head_o     (head)
  );

  fra_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_item_i   (head),
    .q_pop_o    (q_pop),
    .stride_i   (stride_q),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_o      (res)
  );

  assign status_o            = res.status;
  assign slot_number_o       = res.slot;
  assign write_offset_o      = res.offset;
  assign write_length_o      = res.length;
  assign frame_done_o        = res.done;
  assign done_frame_number_o = res.done_fid;
  assign done_width_o        = res.done_w;
  assign done_height_o       = res.done_h;
  assign done_frame_bytes_o  = res.done_bytes;

endmodule
